>>> hw/rtl/msd_pkg.sv
// Package for the Morse signal decoder: item types, queue entry type,
// register indexes, reset values and the symbol lookup table.
// No dependencies; every other file uses it.
`timescale 1ns / 1ps

package msd_pkg;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_DOT_LENGTH        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DASH_LENGTH       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LETTER_GAP_LENGTH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_TOLERANCE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WORD_GAP_MINIMUM  = 3'd4;

    localparam logic [15:0] RESET_DOT_LENGTH        = 16'd30;
    localparam logic [15:0] RESET_DASH_LENGTH       = 16'd60;
    localparam logic [15:0] RESET_LETTER_GAP_LENGTH = 16'd30;
    localparam logic [7:0]  RESET_LENGTH_TOLERANCE  = 8'd5;
    localparam logic [15:0] RESET_WORD_GAP_MINIMUM  = 16'd40;

    // Symbol as carried through the queue
    localparam int SYM_LEN_W = 3;
    localparam int SYM_PAT_W = 5;

    // Queue between the front and the back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;
    localparam int QUEUE_CNT_W = 3;

    localparam logic [6:0] CHAR_SPACE = 7'h20;
    localparam logic [6:0] CHAR_NONE  = 7'h00;

    typedef struct packed {
        logic signed [15:0] sample_value;
        logic               end_of_stream;
    } t_sample_item;

    typedef struct packed {
        logic [6:0] char_code;
        logic       invalid_symbol;
        logic       last_of_run;
    } t_char_item;

    typedef struct packed {
        logic [SYM_LEN_W-1:0] len;
        logic [SYM_PAT_W-1:0] pat;
    } t_symbol;

    // One queue entry holds every request that a single sample causes.
    typedef struct packed {
        logic    emit_sym;
        t_symbol sym;
        logic    word_space;
        logic    flush;
        t_symbol flush_sym;
    } t_entry;

    typedef struct packed {
        logic [6:0] char_code;
        logic       invalid_symbol;
    } t_result;

    // Element i of a symbol sits at bit i, a dash is a one.
    function automatic t_result decode_symbol(input t_symbol s);
        t_result r;
        r.invalid_symbol = 1'b0;
        unique case ({s.len, s.pat})
            {3'd2, 5'd2}:  r.char_code = 7'h41; // A
            {3'd4, 5'd1}:  r.char_code = 7'h42; // B
            {3'd4, 5'd5}:  r.char_code = 7'h43; // C
            {3'd3, 5'd1}:  r.char_code = 7'h44; // D
            {3'd1, 5'd0}:  r.char_code = 7'h45; // E
            {3'd4, 5'd4}:  r.char_code = 7'h46; // F
            {3'd3, 5'd3}:  r.char_code = 7'h47; // G
            {3'd4, 5'd0}:  r.char_code = 7'h48; // H
            {3'd2, 5'd0}:  r.char_code = 7'h49; // I
            {3'd4, 5'd14}: r.char_code = 7'h4A; // J
            {3'd3, 5'd5}:  r.char_code = 7'h4B; // K
            {3'd4, 5'd2}:  r.char_code = 7'h4C; // L
            {3'd2, 5'd3}:  r.char_code = 7'h4D; // M
            {3'd2, 5'd1}:  r.char_code = 7'h4E; // N
            {3'd3, 5'd7}:  r.char_code = 7'h4F; // O
            {3'd4, 5'd6}:  r.char_code = 7'h50; // P
            {3'd4, 5'd11}: r.char_code = 7'h51; // Q
            {3'd3, 5'd2}:  r.char_code = 7'h52; // R
            {3'd3, 5'd0}:  r.char_code = 7'h53; // S
            {3'd1, 5'd1}:  r.char_code = 7'h54; // T
            {3'd3, 5'd4}:  r.char_code = 7'h55; // U
            {3'd4, 5'd8}:  r.char_code = 7'h56; // V
            {3'd3, 5'd6}:  r.char_code = 7'h57; // W
            {3'd4, 5'd9}:  r.char_code = 7'h58; // X
            {3'd4, 5'd13}: r.char_code = 7'h59; // Y
            {3'd4, 5'd3}:  r.char_code = 7'h5A; // Z
            {3'd5, 5'd30}: r.char_code = 7'h31; // 1
            {3'd5, 5'd28}: r.char_code = 7'h32; // 2
            {3'd5, 5'd24}: r.char_code = 7'h33; // 3
            {3'd5, 5'd16}: r.char_code = 7'h34; // 4
            {3'd5, 5'd0}:  r.char_code = 7'h35; // 5
            {3'd5, 5'd1}:  r.char_code = 7'h36; // 6
            {3'd5, 5'd3}:  r.char_code = 7'h37; // 7
            {3'd5, 5'd7}:  r.char_code = 7'h38; // 8
            {3'd5, 5'd15}: r.char_code = 7'h39; // 9
            {3'd5, 5'd31}: r.char_code = 7'h30; // 0
            default: begin
                r.char_code      = CHAR_NONE;
                r.invalid_symbol = 1'b1;
            end
        endcase
        return r;
    endfunction

endpackage

>>> hw/rtl/msd_in_if.sv
// Input channel of the Morse signal decoder: valid/ready plus one sample item.
// Depends on msd_pkg for the payload type.
`timescale 1ns / 1ps

interface msd_in_if;
    logic                 valid;
    logic                 ready;
    msd_pkg::t_sample_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/msd_out_if.sv
// Output channel of the Morse signal decoder: valid/ready plus one character.
// Depends on msd_pkg for the payload type.
`timescale 1ns / 1ps

interface msd_out_if;
    logic               valid;
    logic               ready;
    msd_pkg::t_char_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/msd_front.sv
// Front end: holds the configuration registers, measures key runs, builds
// the pending symbol and pushes one queue entry per sample that emits.
// Depends on msd_pkg and msd_in_if.
`timescale 1ns / 1ps

module msd_front #(
    parameter int MAX_ELEMENTS = 5
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    msd_in_if.sink                             i_sample,
    input  logic                               i_cfg_we,
    input  logic [msd_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [msd_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                               i_q_full,
    output logic                               o_q_push,
    output msd_pkg::t_entry                    o_q_data
);
    import msd_pkg::*;

    localparam int LEN_W = $clog2(MAX_ELEMENTS + 2);

    logic [15:0] r_dot_length, r_dash_length, r_letter_gap_length, r_word_gap_minimum;
    logic [7:0]  r_length_tolerance;

    logic                    r_seen_first, n_seen_first;
    logic                    r_key_level, n_key_level;
    logic [15:0]             r_run_count, n_run_count;
    logic [MAX_ELEMENTS-1:0] r_pattern, n_pattern;
    logic [LEN_W-1:0]        r_length, n_length;

    logic fire;
    logic key_on;

    function automatic logic near_len(input logic [15:0] nominal, input logic [15:0] n,
                                      input logic [7:0] tol);
        logic [15:0] d;
        d = (nominal > n) ? (nominal - n) : (n - nominal);
        return d < {8'd0, tol};
    endfunction

    assign i_sample.ready = !i_q_full;
    assign fire   = i_sample.valid && !i_q_full;
    assign key_on = |i_sample.data.sample_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dot_length        <= RESET_DOT_LENGTH;
            r_dash_length       <= RESET_DASH_LENGTH;
            r_letter_gap_length <= RESET_LETTER_GAP_LENGTH;
            r_length_tolerance  <= RESET_LENGTH_TOLERANCE;
            r_word_gap_minimum  <= RESET_WORD_GAP_MINIMUM;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DOT_LENGTH:        r_dot_length        <= i_cfg_data;
                CFG_DASH_LENGTH:       r_dash_length       <= i_cfg_data;
                CFG_LETTER_GAP_LENGTH: r_letter_gap_length <= i_cfg_data;
                CFG_LENGTH_TOLERANCE:  r_length_tolerance  <= i_cfg_data[7:0];
                CFG_WORD_GAP_MINIMUM:  r_word_gap_minimum  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        logic add_el;
        logic is_dash;
        n_seen_first = r_seen_first;
        n_key_level  = r_key_level;
        n_run_count  = r_run_count;
        n_pattern    = r_pattern;
        n_length     = r_length;
        add_el       = 1'b0;
        is_dash      = 1'b0;
        o_q_data     = '0;

        if (fire) begin
            if (!r_seen_first) begin
                n_seen_first = 1'b1;
                n_key_level  = key_on;
                n_run_count  = 16'd1;
            end else if (key_on == r_key_level) begin
                if (r_run_count != 16'hFFFF) begin
                    n_run_count = r_run_count + 16'd1;
                end
            end else begin
                if (r_key_level) begin
                    if (near_len(r_dot_length, r_run_count, r_length_tolerance)) begin
                        add_el = 1'b1;
                    end else if (near_len(r_dash_length, r_run_count, r_length_tolerance)) begin
                        add_el  = 1'b1;
                        is_dash = 1'b1;
                    end
                end else begin
                    if (near_len(r_letter_gap_length, r_run_count, r_length_tolerance)) begin
                        o_q_data.emit_sym = 1'b1;
                    end else if (r_run_count > r_word_gap_minimum) begin
                        o_q_data.emit_sym   = 1'b1;
                        o_q_data.word_space = 1'b1;
                    end
                end
                n_run_count = '0;
                n_key_level = key_on;
            end

            if (add_el) begin
                if (r_length < LEN_W'(MAX_ELEMENTS)) begin
                    n_pattern = r_pattern | (MAX_ELEMENTS'(is_dash) << r_length);
                    n_length  = r_length + LEN_W'(1);
                end else begin
                    // Too many elements: park the length one past the limit.
                    n_length = LEN_W'(MAX_ELEMENTS + 1);
                end
            end

            if (o_q_data.emit_sym) begin
                o_q_data.sym.len = SYM_LEN_W'(r_length);
                o_q_data.sym.pat = r_pattern[SYM_PAT_W-1:0];
                n_pattern = '0;
                n_length  = '0;
            end

            if (i_sample.data.end_of_stream) begin
                o_q_data.flush         = 1'b1;
                o_q_data.flush_sym.len = SYM_LEN_W'(n_length);
                o_q_data.flush_sym.pat = n_pattern[SYM_PAT_W-1:0];
                n_pattern    = '0;
                n_length     = '0;
                n_seen_first = 1'b0;
                n_key_level  = 1'b0;
                n_run_count  = '0;
            end
        end
    end

    assign o_q_push = fire && (o_q_data.emit_sym || o_q_data.flush);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_first <= 1'b0;
            r_key_level  <= 1'b0;
            r_run_count  <= '0;
            r_pattern    <= '0;
            r_length     <= '0;
        end else begin
            r_seen_first <= n_seen_first;
            r_key_level  <= n_key_level;
            r_run_count  <= n_run_count;
            r_pattern    <= n_pattern;
            r_length     <= n_length;
        end
    end

endmodule

>>> hw/rtl/msd_fifo.sv
// Short queue of emit requests between the front and the back end.
// Depends on msd_pkg for the entry type and depth.
`timescale 1ns / 1ps

module msd_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  msd_pkg::t_entry i_data,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_valid,
    output msd_pkg::t_entry o_data
);
    import msd_pkg::*;

    t_entry                 r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QUEUE_CNT_W-1:0] r_count, n_count;

    assign o_full  = (r_count == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + QUEUE_CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - QUEUE_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QUEUE_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QUEUE_PTR_W'(1);
            end
            r_count <= n_count;
        end
    end

endmodule

>>> hw/rtl/msd_back.sv
// Back end: takes one queue entry, decodes its symbols and hands out the
// resulting characters one request at a time. Depends on msd_pkg, msd_out_if.
`timescale 1ns / 1ps

module msd_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  msd_pkg::t_entry i_q_data,
    output logic            o_q_pop,
    msd_out_if.source       o_char
);
    import msd_pkg::*;

    // Slot 0: letter or word end symbol, slot 1: word space, slot 2: flush.
    logic       r_valid;
    logic [2:0] r_mask;
    t_result    r_res_sym, r_res_flush;

    logic    fire;
    logic    last;
    t_result cur;

    assign fire = r_valid && o_char.ready;
    assign last = ((r_mask & (r_mask - 3'd1)) == 3'd0);
    assign o_q_pop = i_q_valid && (!r_valid || (fire && last));

    always_comb begin
        priority if (r_mask[0]) begin
            cur = r_res_sym;
        end else if (r_mask[1]) begin
            cur.char_code      = CHAR_SPACE;
            cur.invalid_symbol = 1'b0;
        end else begin
            cur = r_res_flush;
        end
    end

    assign o_char.valid               = r_valid;
    assign o_char.data.char_code      = cur.char_code;
    assign o_char.data.invalid_symbol = cur.invalid_symbol;
    assign o_char.data.last_of_run    = last;

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_res_sym   <= decode_symbol(i_q_data.sym);
            r_res_flush <= decode_symbol(i_q_data.flush_sym);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_mask  <= '0;
        end else if (o_q_pop) begin
            r_valid <= 1'b1;
            r_mask  <= {i_q_data.flush, i_q_data.word_space, i_q_data.emit_sym};
        end else if (fire) begin
            if (last) begin
                r_valid <= 1'b0;
                r_mask  <= '0;
            end else begin
                // Retire the lowest pending slot.
                r_mask <= r_mask & (r_mask - 3'd1);
            end
        end
    end

endmodule

>>> hw/rtl/morse_signal_decoder_top.sv
// A character's request is written to the request queue, then to the output stage.
// Throughput: one sample per cycle while the queue has room; one character per cycle while ready.
// A sample can cause up to three characters, which leave one after the other.
// Reset is synchronous, active low: it clears run tracking, the pending symbol,
// the request queue and the output stage, and reloads register defaults.
`timescale 1ns / 1ps

// Morse signal decoder, top level.
//
// The design is split into a front end and a back end joined by a four-entry
// request queue:
//   - msd_front accepts one sample per cycle unless the queue is full. It compares
//     the sample with the current key level, counts the run length (saturating
//     at 65535) and, on a level change, classifies the finished run against the
//     configured dot, dash, letter gap and word gap lengths. Matching on-runs
//     append an element to the pending symbol; off-runs that end a letter or a
//     word, and an end of stream flag, produce a queue entry of what to emit.
//   - msd_fifo holds those entries so that a slow consumer does not stall the
//     sample stream until the queue is full.
//   - msd_back pops one entry, decodes its symbols through the lookup table in
//     the package and presents the characters one after the other. The last
//     character caused by a sample carries last_of_run.
//
// The input is ready whenever the queue has room, independently of the output
// side. Samples that emit nothing never use a queue slot, so the sustained
// input rate is one sample per cycle as long as the output keeps up with the
// characters; the output stage is the single point that limits the character
// rate to one per cycle.
//
// Configuration writes go straight to the registers in the front end and are
// expected only while the decoder is idle. An index beyond the register list
// is ignored.
module morse_signal_decoder_top #(
    parameter int MAX_ELEMENTS = 5
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    msd_in_if.sink                         i_sample,
    msd_out_if.source                      o_char,
    input  logic                           i_cfg_we,
    input  logic [msd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [msd_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import msd_pkg::*;

    logic   q_push;
    t_entry q_in;
    logic   q_full;
    logic   q_valid;
    t_entry q_out;
    logic   q_pop;

    msd_front #(
        .MAX_ELEMENTS(MAX_ELEMENTS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_sample   (i_sample),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_q_data   (q_in)
    );

    msd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_out)
    );

    msd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_data  (q_out),
        .o_q_pop   (q_pop),
        .o_char    (o_char)
    );

endmodule

>>> verif/tb_morse_signal_decoder_top.sv
// Self-checking testbench for morse_signal_decoder_top: drives keyed sample streams,
// predicts the decoded characters and compares them with the output channel.
// Depends on msd_pkg, msd_in_if, msd_out_if and the decoder RTL.
`timescale 1ns / 1ps

module tb_morse_signal_decoder_top;
    import msd_pkg::*;

    localparam int CLK_HALF       = 6;
    localparam int CLK_PERIOD     = 2 * CLK_HALF;
    localparam int RESET_CYCLES   = 12;
    localparam int MAX_ELEMENTS   = 5;
    // A character passes the request queue and output stage; give the pipeline some slack.
    localparam int DRAIN_CYCLES   = 8;
    localparam int TIMEOUT_CYCLES = 100_000;
    localparam int MAX_REPORTS    = 10;
    localparam int SIGN_COUNT     = 36;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    msd_in_if  sample_if ();
    msd_out_if char_if ();

    morse_signal_decoder_top #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_sample   (sample_if),
        .o_char     (char_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #CLK_HALF;
        i_clk = 1'b1;
        #CLK_HALF;
    end

    // International Morse for the letters and digits, dot '.' and dash '-'.
    // Entry i of the code list decodes to character i of the sign string.
    string morse_codes [SIGN_COUNT] = '{
        ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..", ".---",
        "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-",
        "..-", "...-", ".--", "-..-", "-.--", "--..",
        ".----", "..---", "...--", "....-", ".....",
        "-....", "--...", "---..", "----.", "-----"
    };
    string morse_signs = "ABCDEFGHIJKLMNOPQRSTUVWXYZ1234567890";

    // Register shadow, updated on every write that the decoder sees.
    logic [15:0] cfg_dot;
    logic [15:0] cfg_dash;
    logic [15:0] cfg_gap;
    logic [7:0]  cfg_tol;
    logic [15:0] cfg_word;

    // Decoder state as the predictor tracks it.
    logic        stream_started;
    logic        key_down;
    logic [15:0] run_len;
    logic [4:0]  sym_pat;
    logic [2:0]  sym_len;
    logic        space_pending;

    t_char_item char_expect [$];
    t_char_item step_chars [$];

    // Run lengths the stimulus aims at for the current register setting. A run
    // of n is sent as n + 1 samples because the sample that changes the level
    // is not counted in the new run.
    int key_dot, key_dash, key_space, key_gap, key_word;

    int  items_sent;
    int  chars_predicted;
    int  error_count;
    int  hold_request;
    bit  src_idle_en;
    bit  sink_idle_en;

    // ------------------------------------------------------------------
    // Character predictor
    // ------------------------------------------------------------------

    function automatic void predictor_reset();
        cfg_dot        = RESET_DOT_LENGTH;
        cfg_dash       = RESET_DASH_LENGTH;
        cfg_gap        = RESET_LETTER_GAP_LENGTH;
        cfg_tol        = RESET_LENGTH_TOLERANCE;
        cfg_word       = RESET_WORD_GAP_MINIMUM;
        stream_started = 1'b0;
        key_down       = 1'b0;
        run_len        = '0;
        sym_pat        = '0;
        sym_len        = '0;
        space_pending  = 1'b0;
    endfunction

    function automatic bit run_matches(logic [15:0] nominal, logic [15:0] n);
        int unsigned diff;
        diff = (nominal > n) ? nominal - n : n - nominal;
        return diff < cfg_tol;
    endfunction

    function automatic void append_element(logic is_dash);
        if (sym_len < MAX_ELEMENTS) begin
            sym_pat[sym_len] = is_dash;
            sym_len          = sym_len + 3'd1;
        end else begin
            sym_len = 3'(MAX_ELEMENTS + 1);
        end
    endfunction

    // Returns the position of the pending symbol in the code list, or -1.
    function automatic int find_sign(logic [2:0] len, logic [4:0] pat);
        string code;
        bit    hit;
        if (len == 0 || len > MAX_ELEMENTS) return -1;
        for (int i = 0; i < SIGN_COUNT; i++) begin
            code = morse_codes[i];
            if (code.len() == len) begin
                hit = 1'b1;
                for (int k = 0; k < len; k++) begin
                    if ((code[k] == "-") != pat[k]) hit = 1'b0;
                end
                if (hit) return i;
            end
        end
        return -1;
    endfunction

    function automatic void emit_pending();
        t_char_item c;
        int         idx;
        byte        sign;
        c.last_of_run    = 1'b0;
        c.invalid_symbol = 1'b0;
        if (space_pending) begin
            c.char_code = CHAR_SPACE;
        end else begin
            idx = find_sign(sym_len, sym_pat);
            if (idx < 0) begin
                c.char_code      = CHAR_NONE;
                c.invalid_symbol = 1'b1;
            end else begin
                sign        = morse_signs[idx];
                c.char_code = sign[6:0];
            end
        end
        step_chars    = {step_chars, c};
        sym_pat       = '0;
        sym_len       = '0;
        space_pending = 1'b0;
    endfunction

    // Advances the predicted state by one accepted sample and queues the
    // characters it causes; only the final one carries last_of_run.
    function automatic void predict_chars(t_sample_item item);
        logic        level;
        logic [15:0] n;
        t_char_item  c;
        level = (item.sample_value != 0);
        step_chars.delete();
        if (!stream_started) begin
            stream_started = 1'b1;
            key_down       = level;
            run_len        = 16'd1;
        end else if (level == key_down) begin
            if (run_len != 16'hFFFF) run_len = run_len + 16'd1;
        end else begin
            n = run_len;
            if (key_down) begin
                if (run_matches(cfg_dot, n)) append_element(1'b0);
                else if (run_matches(cfg_dash, n)) append_element(1'b1);
            end else begin
                if (run_matches(cfg_gap, n)) begin
                    emit_pending();
                end else if (n > cfg_word) begin
                    emit_pending();
                    space_pending = 1'b1;
                    emit_pending();
                end
            end
            run_len  = '0;
            key_down = level;
        end
        if (item.end_of_stream) begin
            emit_pending();
            stream_started = 1'b0;
            key_down       = 1'b0;
            run_len        = '0;
        end
        foreach (step_chars[i]) begin
            c             = step_chars[i];
            c.last_of_run = (i == step_chars.size() - 1);
            char_expect   = {char_expect, c};
            chars_predicted++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Shared drivers
    // ------------------------------------------------------------------

    // Mostly back to back, sometimes a short gap, now and then a long gap.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic signed [15:0] key_value();
        logic signed [15:0] v;
        v = 16'($urandom_range(1, 16'hFFFF));
        return v;
    endfunction

    function automatic void note_error(string msg);
        error_count++;
        if (error_count <= MAX_REPORTS) $display("ERROR at %0t: %s", $time, msg);
    endfunction

    // Offers one sample and returns at the edge where it is accepted. Valid
    // stays high so that the next request can follow without a bubble.
    task automatic send_sample(input logic signed [15:0] value, input logic eos);
        t_sample_item item;
        int           gap;
        item.sample_value  = value;
        item.end_of_stream = eos;
        gap = src_idle_en ? pick_gap() : 0;
        if (gap > 0) begin
            sample_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        sample_if.valid <= 1'b1;
        sample_if.data  <= item;
        do @(posedge i_clk); while (!sample_if.ready);
        items_sent++;
        predict_chars(item);
    endtask

    // A run of length n at one key level, optionally ending the stream on its
    // last sample.
    task automatic send_run(input logic level, input int n, input logic eos);
        for (int i = 0; i <= n; i++) begin
            send_sample(level ? key_value() : 16'sd0, eos && (i == n));
        end
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        case (idx)
            CFG_DOT_LENGTH:        cfg_dot  = value;
            CFG_DASH_LENGTH:       cfg_dash = value;
            CFG_LETTER_GAP_LENGTH: cfg_gap  = value;
            CFG_LENGTH_TOLERANCE:  cfg_tol  = value[7:0];
            CFG_WORD_GAP_MINIMUM:  cfg_word = value;
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [15:0] dot, input logic [15:0] dash,
                              input logic [15:0] gap, input logic [15:0] tol,
                              input logic [15:0] word);
        cfg_write(CFG_DOT_LENGTH, dot);
        cfg_write(CFG_DASH_LENGTH, dash);
        cfg_write(CFG_LETTER_GAP_LENGTH, gap);
        cfg_write(CFG_LENGTH_TOLERANCE, tol);
        cfg_write(CFG_WORD_GAP_MINIMUM, word);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_keying(input int dot, input int dash, input int space,
                              input int gap, input int word);
        key_dot   = dot;
        key_dash  = dash;
        key_space = space;
        key_gap   = gap;
        key_word  = word;
    endtask

    // Drops valid, waits for every predicted character, then lets the
    // pipeline settle so that samples causing nothing are also through.
    task automatic wait_idle();
        sample_if.valid <= 1'b0;
        while (char_expect.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Most runs hit the nominal length; some are off by a little so that
    // they fall into a neighboring class or are ignored.
    function automatic int jitter(int n);
        int r;
        r = $urandom_range(0, 99);
        if (r < 88) return n;
        if (r < 96) return n + $urandom_range(1, 3);
        return (n > 0) ? n - 1 : 0;
    endfunction

    task automatic send_code(input string code);
        for (int e = 0; e < code.len(); e++) begin
            if (e > 0) send_run(1'b0, jitter(key_space), 1'b0);
            send_run(1'b1, jitter(code[e] == "-" ? key_dash : key_dot), 1'b0);
        end
    endtask

    // Well-formed letters and words with random content, plus noise runs,
    // random element patterns and stream ends at random points.
    task automatic send_random_letters(input int min_items, input int min_chars);
        int    first_item;
        int    first_char;
        int    r;
        string code;
        first_item = items_sent;
        first_char = chars_predicted;
        while (items_sent - first_item < min_items || chars_predicted - first_char < min_chars)
        begin
            if ($urandom_range(0, 99) < 12) src_idle_en = !src_idle_en;
            if ($urandom_range(0, 99) < 12) sink_idle_en = !sink_idle_en;
            if ($urandom_range(0, 99) < 8) begin
                send_run(1'b1, $urandom_range(0, 6), 1'b0);
                send_run(1'b0, $urandom_range(0, 6), 1'b0);
            end
            if ($urandom_range(0, 99) < 80) begin
                code = morse_codes[$urandom_range(0, SIGN_COUNT - 1)];
            end else begin
                // Random patterns reach the unknown, empty and overlong symbols.
                code = "";
                repeat ($urandom_range(0, MAX_ELEMENTS + 1)) begin
                    code = {code, ($urandom_range(0, 1) ? "-" : ".")};
                end
            end
            send_code(code);
            r = $urandom_range(0, 99);
            if (r < 60) begin
                send_run(1'b0, jitter(key_gap), $urandom_range(0, 99) < 6);
            end else begin
                send_run(1'b0, key_word + $urandom_range(0, 3), $urandom_range(0, 99) < 6);
            end
        end
    endtask

    // Runs of random length, up to six, at alternating levels.
    task automatic send_random_runs(input int min_items);
        int   first_item;
        logic level;
        first_item = items_sent;
        level      = 1'b0;
        while (items_sent - first_item < min_items) begin
            send_run(level, $urandom_range(0, 6), $urandom_range(0, 9) == 0);
            level = !level;
        end
    endtask

    // ------------------------------------------------------------------
    // Output side: ready generation and the result check
    // ------------------------------------------------------------------

    // Ready is decided at the edge before its cycle. A hold request from a test keeps the
    // sink closed for that many cycles regardless of the idle setting.
    initial begin : char_sink
        int stall;
        stall = 0;
        char_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request > 0) begin
                stall        = hold_request;
                hold_request = 0;
            end
            if (stall > 0) begin
                char_if.ready <= 1'b0;
                stall--;
            end else begin
                char_if.ready <= 1'b1;
                if (sink_idle_en) stall = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin : char_check
        t_char_item want;
        if (i_rst_n && char_if.valid && char_if.ready) begin
            if (char_expect.size() == 0) begin
                note_error($sformatf("unexpected char: code %02h inv %0b last %0b",
                           char_if.data.char_code, char_if.data.invalid_symbol,
                           char_if.data.last_of_run));
            end else begin
                want = char_expect.pop_front();
                if (char_if.data.char_code !== want.char_code ||
                    char_if.data.invalid_symbol !== want.invalid_symbol ||
                    char_if.data.last_of_run !== want.last_of_run) begin
                    note_error($sformatf(
                        "char mismatch: want code %02h inv %0b last %0b, got %02h %0b %0b",
                        want.char_code, want.invalid_symbol, want.last_of_run,
                        char_if.data.char_code, char_if.data.invalid_symbol,
                        char_if.data.last_of_run));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Ending a stream always emits the pending symbol; with nothing keyed it
    // comes out as an invalid character.
    task automatic test_flush_at_defaults();
        send_sample(16'sd0, 1'b1);
        send_sample(16'sh8000, 1'b1);
        wait_idle();
    endtask

    // Compact timing so that letters take few samples. The tolerance write
    // carries junk in its upper byte, and writes to the spare indexes must
    // leave every register alone.
    task automatic test_register_decode();
        set_config(16'd0, 16'd1, 16'd1, 16'hFF01, 16'd1);
        set_keying(0, 1, 0, 1, 2);
        for (int r = CFG_WORD_GAP_MINIMUM + 1; r < (1 << CFG_IDX_W); r++) begin
            cfg_write(CFG_IDX_W'(r), 16'hFFFF);
        end
        i_cfg_we <= 1'b0;
    endtask

    // A dash, a letter end, a dot, a word end that coincides with a stream
    // end (the three-character case), then a six-element symbol.
    task automatic test_directed_keying();
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        send_sample(16'sd0, 1'b0);
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sh0001, 1'b0);
        send_sample(16'sd0, 1'b0);
        send_sample(16'sd0, 1'b0);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sd0, 1'b0);
        send_sample(16'sd0, 1'b0);
        send_sample(16'sd0, 1'b0);
        send_sample(16'sd0, 1'b0);
        send_sample(-16'sd1, 1'b1);
        // The stream restarts on a key-down sample, so the first element is a
        // dash; five dots follow and overflow the symbol.
        for (int e = 0; e < MAX_ELEMENTS + 1; e++) begin
            send_sample(e[0] ? 16'sh5555 : 16'sh2AAA, 1'b0);
            send_sample(16'sd0, e == MAX_ELEMENTS);
        end
        wait_idle();
    endtask

    task automatic test_random_keying();
        send_random_letters(24, 3);
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
        wait_idle();
    endtask

    // Register extremes: first nothing can match and only stream ends emit,
    // then every on-run is a dot and almost every off-run ends a letter, then
    // a middle setting with wider runs.
    task automatic test_register_sweep();
        set_config(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF);
        send_random_runs(8);
        wait_idle();
        set_config(16'h0000, 16'hFFFF, 16'h0000, 16'h00FF, 16'h0000);
        send_random_runs(8);
        wait_idle();
        set_config(16'd2, 16'd5, 16'd3, 16'd2, 16'd6);
        set_keying(2, 5, 0, 3, 7);
        send_random_letters(12, 1);
        wait_idle();
    endtask

    // Every sample ends a stream, so each one queues a character. With the
    // sink closed the request queue fills and the input must stall.
    task automatic test_backpressure();
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        hold_request = 150;
        for (int i = 0; i < 16; i++) begin
            send_sample(i[0] ? key_value() : 16'sd0, 1'b1);
        end
        wait_idle();
    endtask

    initial begin : main_sequence
        items_sent      = 0;
        chars_predicted = 0;
        error_count     = 0;
        hold_request    = 0;
        src_idle_en     = 1'b1;
        sink_idle_en    = 1'b1;
        predictor_reset();
        set_keying(0, 1, 0, 1, 2);
        i_rst_n         <= 1'b0;
        sample_if.valid <= 1'b0;
        sample_if.data  <= '0;
        i_cfg_we        <= 1'b0;
        i_cfg_idx       <= '0;
        i_cfg_data      <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_flush_at_defaults();
        test_register_decode();
        test_directed_keying();
        test_random_keying();
        test_register_sweep();
        test_backpressure();

        if (error_count == 0) begin
            $display("morse_signal_decoder_top test passed");
        end else begin
            $display("morse_signal_decoder_top test failed");
        end
        $finish;
    end

    // Generous bound on the whole run: it allows for every sample sent, each with
    // the longest gaps on both sides and three characters, plus the long hold.
    initial begin : watchdog
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("morse_signal_decoder_top test failed");
        $finish;
    end

endmodule
